// ===== hw/rtl/smi_pkg.sv =====
// Shared types and request codes for the symbol mutation injector.
`timescale 1ns / 1ps

package smi_pkg;

    localparam int TYPE_W = 3;
    localparam int SYM_W  = 8;
    localparam int QUAL_W = 8;
    localparam int RAND_W = 16;
    localparam int WIN_W  = 16;

    localparam logic [TYPE_W-1:0] REQ_PROCESS  = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_END      = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_LOAD_SUB = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_LOAD_INS = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LOAD_DEL = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SYM_W-1:0]  symbol;
        logic [SYM_W-1:0]  target_symbol;
        logic [QUAL_W-1:0] quality;
        logic [RAND_W-1:0] random_value;
        logic [WIN_W-1:0]  weight;
    } t_smi_req;

    typedef struct packed {
        logic [SYM_W-1:0]  out_symbol;
        logic [QUAL_W-1:0] out_quality;
        logic              has_symbol;
        logic              read_end;
        logic              last;
    } t_smi_res;

endpackage

// ===== hw/rtl/smi_req_if.sv =====
// Request channel interface: valid, ready and one request payload.
`timescale 1ns / 1ps

interface smi_req_if;
    import smi_pkg::*;

    logic     valid;
    logic     ready;
    t_smi_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smi_res_if.sv =====
// Result channel interface: valid, ready and one result payload.
`timescale 1ns / 1ps

interface smi_res_if;
    import smi_pkg::*;

    logic     valid;
    logic     ready;
    t_smi_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/symbol_mutation_injector.sv =====
// Symbol mutation injector: weight tables in memory, walked per request.
//
// Channels: i_req takes requests (process symbol, end of read, and weight
// loads for substitution, insertion and deletion); o_res gives results.
// A request is taken when valid and ready are both high at a clock edge.
// Requests are handled one at a time; ready is high only while idle.
// A load reads the old entry, then writes the new weight and, for substitution
// and insertion, the updated total. A process request checks, in order, the
// row total, the insertion total and the delete weight; when the row or
// insertion total is hit, a table walk reads one weight from memory per cycle,
// up to SYMBOL_COUNT entries, and the result then goes to the result register.
// Insertion during processing yields two results: inserted symbol, then
// the input symbol. End of read always yields exactly one result.
// Reset starts a clearing pass over all SYMBOL_COUNT * SYMBOL_COUNT entries that
// zeroes all tables; no request is taken until it ends.
// Results sit in an output register; a stalled receiver holds it and the
// sequencer waits only when it has a further result to hand over.
`timescale 1ns / 1ps

module symbol_mutation_injector #(
    parameter int SYMBOL_COUNT = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smi_req_if.sink   i_req,
    smi_res_if.source o_res
);
    import smi_pkg::*;

    localparam int SYM_BITS  = $clog2(SYMBOL_COUNT);
    localparam int WB        = WEIGHT_BITS;
    localparam int TB        = WEIGHT_BITS + SYM_BITS;
    localparam int SUB_DEPTH = SYMBOL_COUNT * SYMBOL_COUNT;
    localparam int SUB_AW    = $clog2(SUB_DEPTH);
    localparam int SHL       = (WB >= RAND_W) ? WB - RAND_W : 0;
    localparam int SHR       = (WB >= RAND_W) ? 0 : RAND_W - WB;
    localparam logic [SYM_BITS-1:0] LAST_IDX = SYM_BITS'(SYMBOL_COUNT - 1);
    localparam logic [SUB_AW-1:0]   CLR_LAST = SUB_AW'(SUB_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LOOK    = 3'd2;
    localparam logic [2:0] ST_CHK_INS = 3'd3;
    localparam logic [2:0] ST_CHK_DEL = 3'd4;
    localparam logic [2:0] ST_WALK    = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    localparam logic TSEL_SUB = 1'b0;
    localparam logic TSEL_INS = 1'b1;

    logic [WB-1:0] m_sub [SUB_DEPTH];
    logic [TB-1:0] m_row [SYMBOL_COUNT];
    logic [WB-1:0] m_ins [SYMBOL_COUNT];
    logic [WB-1:0] m_del [SYMBOL_COUNT];

    logic [2:0]          r_state, n_state;
    logic [SUB_AW-1:0]   r_clr, n_clr;
    logic [WB-1:0]       r_p, n_p;
    logic [SYM_BITS-1:0] r_widx, n_widx;
    logic                r_tsel, n_tsel;
    t_smi_res            r_pend, n_pend;
    logic                r_second, n_second;
    logic [TB-1:0]       r_ins_total, n_ins_total;
    logic                r_ov;
    t_smi_res            r_out;

    logic [TYPE_W-1:0]   r_type;
    logic [SYM_W-1:0]    r_sym;
    logic [QUAL_W-1:0]   r_qual;
    logic [WB-1:0]       r_w;
    logic [SYM_BITS-1:0] r_sidx;
    logic                r_ok;
    logic                r_tok;
    logic [SUB_AW-1:0]   r_base;
    logic [SUB_AW-1:0]   r_sub_addr;

    logic [WB-1:0] r_sub_rd;
    logic [TB-1:0] r_row_rd;
    logic [WB-1:0] r_ins_rd;
    logic [WB-1:0] r_del_rd;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [SYM_BITS-1:0] acc_sidx;
    logic [SUB_AW-1:0]   acc_base;
    logic [SUB_AW-1:0]   acc_sub_addr;
    logic [WB-1:0]       acc_p;
    logic                clr_small;
    logic [TB-1:0]       row_val;
    logic [WB-1:0]       del_val;
    logic [WB-1:0]       walk_w;
    logic                walk_hit;
    logic [SYM_BITS-1:0] walk_nxt;
    t_smi_res            copy_res;
    t_smi_res            end_res;

    logic                sub_we, sub_re, row_we, row_re, ins_we, ins_re, del_we, del_re;
    logic [SUB_AW-1:0]   sub_wa, sub_ra;
    logic [WB-1:0]       sub_wd, ins_wd, del_wd;
    logic [TB-1:0]       row_wd;
    logic [SYM_BITS-1:0] row_wa, row_ra, ins_wa, ins_ra, del_wa, del_ra;

    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = (r_state == ST_IDLE);
    assign out_free     = !r_ov || o_res.ready;
    assign o_res.valid  = r_ov;
    assign o_res.data   = r_out;

    assign acc_sidx     = i_req.data.symbol[SYM_BITS-1:0];
    assign acc_base     = SUB_AW'(acc_sidx) * SUB_AW'(SYMBOL_COUNT);
    assign acc_sub_addr = acc_base + SUB_AW'(i_req.data.target_symbol[SYM_BITS-1:0]);
    assign acc_p        = (WB >= RAND_W) ? (WB'(i_req.data.random_value) << SHL)
                                         : WB'(i_req.data.random_value >> SHR);

    assign clr_small = (r_clr < SUB_AW'(SYMBOL_COUNT));
    assign row_val   = r_ok ? r_row_rd : '0;
    assign del_val   = r_ok ? r_del_rd : '0;
    assign walk_w    = (r_tsel == TSEL_INS) ? r_ins_rd : r_sub_rd;
    assign walk_hit  = (r_p < walk_w);
    assign walk_nxt  = r_widx + 1'b1;

    always_comb begin
        copy_res.out_symbol  = r_sym;
        copy_res.out_quality = r_qual;
        copy_res.has_symbol  = 1'b1;
        copy_res.read_end    = 1'b0;
        copy_res.last        = 1'b1;
        end_res.out_symbol   = '0;
        end_res.out_quality  = '0;
        end_res.has_symbol   = 1'b0;
        end_res.read_end     = 1'b1;
        end_res.last         = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_p         = r_p;
        n_widx      = r_widx;
        n_tsel      = r_tsel;
        n_pend      = r_pend;
        n_second    = r_second;
        n_ins_total = r_ins_total;
        out_load    = 1'b0;

        sub_we = 1'b0;
        sub_wa = r_sub_addr;
        sub_wd = r_w;
        sub_re = 1'b0;
        sub_ra = acc_sub_addr;
        row_we = 1'b0;
        row_wa = r_sidx;
        row_wd = r_row_rd - TB'(r_sub_rd) + TB'(r_w);
        row_re = 1'b0;
        row_ra = acc_sidx;
        ins_we = 1'b0;
        ins_wa = r_sidx;
        ins_wd = r_w;
        ins_re = 1'b0;
        ins_ra = acc_sidx;
        del_we = 1'b0;
        del_wa = r_sidx;
        del_wd = r_w;
        del_re = 1'b0;
        del_ra = acc_sidx;

        case (r_state)
            ST_CLEAR: begin
                sub_we = 1'b1;
                sub_wa = r_clr;
                sub_wd = '0;
                row_we = clr_small;
                row_wa = r_clr[SYM_BITS-1:0];
                row_wd = '0;
                ins_we = clr_small;
                ins_wa = r_clr[SYM_BITS-1:0];
                ins_wd = '0;
                del_we = clr_small;
                del_wa = r_clr[SYM_BITS-1:0];
                del_wd = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    sub_re  = 1'b1;
                    row_re  = 1'b1;
                    ins_re  = 1'b1;
                    del_re  = 1'b1;
                    n_p     = acc_p;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
                case (r_type)
                    REQ_PROCESS: begin
                        if (TB'(r_p) < row_val) begin
                            sub_re  = 1'b1;
                            sub_ra  = r_base;
                            n_widx  = '0;
                            n_tsel  = TSEL_SUB;
                            n_state = ST_WALK;
                        end else begin
                            n_p     = WB'(TB'(r_p) - row_val);
                            n_state = ST_CHK_INS;
                        end
                    end
                    REQ_END: begin
                        n_state = ST_CHK_INS;
                    end
                    REQ_LOAD_SUB: begin
                        sub_we = r_ok && r_tok;
                        row_we = r_ok && r_tok;
                    end
                    REQ_LOAD_INS: begin
                        ins_we = r_ok;
                        if (r_ok) begin
                            n_ins_total = r_ins_total - TB'(r_ins_rd) + TB'(r_w);
                        end
                    end
                    REQ_LOAD_DEL: begin
                        del_we = r_ok;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_CHK_INS: begin
                if (TB'(r_p) < r_ins_total) begin
                    ins_re  = 1'b1;
                    ins_ra  = '0;
                    n_widx  = '0;
                    n_tsel  = TSEL_INS;
                    n_state = ST_WALK;
                end else if (r_type == REQ_END) begin
                    n_pend   = end_res;
                    n_second = 1'b0;
                    n_state  = ST_EMIT;
                end else begin
                    n_p     = WB'(TB'(r_p) - r_ins_total);
                    n_state = ST_CHK_DEL;
                end
            end
            ST_CHK_DEL: begin
                if (r_p < del_val) begin
                    n_state = ST_IDLE;
                end else begin
                    n_pend   = copy_res;
                    n_second = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_WALK: begin
                if (walk_hit) begin
                    n_pend.out_symbol  = SYM_W'(r_widx);
                    n_pend.out_quality = '0;
                    n_pend.has_symbol  = 1'b1;
                    n_pend.read_end    = (r_type == REQ_END);
                    n_second           = (r_type == REQ_PROCESS) && (r_tsel == TSEL_INS);
                    n_pend.last        = !((r_type == REQ_PROCESS) && (r_tsel == TSEL_INS));
                    n_state            = ST_EMIT;
                end else begin
                    n_p = r_p - walk_w;
                    if (r_widx == LAST_IDX) begin
                        // walk ran off the table
                        if (r_type == REQ_END) begin
                            n_pend   = end_res;
                            n_second = 1'b0;
                            n_state  = ST_EMIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_widx = walk_nxt;
                        sub_ra = r_base + SUB_AW'(walk_nxt);
                        ins_ra = walk_nxt;
                        sub_re = (r_tsel == TSEL_SUB);
                        ins_re = (r_tsel == TSEL_INS);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_second) begin
                        n_pend   = copy_res;
                        n_second = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_second    <= 1'b0;
            r_ins_total <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_second    <= n_second;
            r_ins_total <= n_ins_total;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_widx <= n_widx;
        r_tsel <= n_tsel;
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= r_pend;
        end
        if (accept) begin
            r_type     <= i_req.data.req_type;
            r_sym      <= i_req.data.symbol;
            r_qual     <= i_req.data.quality;
            r_w        <= WB'(i_req.data.weight);
            r_sidx     <= acc_sidx;
            r_ok       <= ({1'b0, i_req.data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
            r_tok      <= ({1'b0, i_req.data.target_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
            r_base     <= acc_base;
            r_sub_addr <= acc_sub_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sub_we) begin
            m_sub[sub_wa] <= sub_wd;
        end
        if (sub_re) begin
            r_sub_rd <= m_sub[sub_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            m_row[row_wa] <= row_wd;
        end
        if (row_re) begin
            r_row_rd <= m_row[row_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_we) begin
            m_ins[ins_wa] <= ins_wd;
        end
        if (ins_re) begin
            r_ins_rd <= m_ins[ins_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (del_we) begin
            m_del[del_wa] <= del_wd;
        end
        if (del_re) begin
            r_del_rd <= m_del[del_ra];
        end
    end

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_ov)
        else $error("result presented during table clear");

    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_LOOK))
        else $error("accepted request not followed by table lookup");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_widx <= LAST_IDX))
        else $error("walk index beyond table");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.read_end) |-> (r_out.last && (r_out.out_quality == '0)))
        else $error("read end result not last or carries quality");

    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.has_symbol) |-> (r_out.read_end && (r_out.out_symbol == '0)))
        else $error("empty result without read end");

endmodule
